### hdl/ph_trimmed_mean_filter_top_macros.svh
// Assertion macros for the pH trimmed mean filter.
`ifndef PH_TRIMMED_MEAN_FILTER_TOP_MACROS_SVH
`define PH_TRIMMED_MEAN_FILTER_TOP_MACROS_SVH
`ifndef SYNTH
`define PH_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define PH_ASSERT_RST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PH_ASSERT(lbl, clk, rstn, prop, msg)
`define PH_ASSERT_RST(lbl, clk, prop, msg)
`endif
`endif

### hdl/ph_tmf_pkg.sv
`default_nettype none
package ph_tmf_pkg;
  localparam int SampleW = 10;
  localparam int MeanW   = 18;
  localparam int VoltW   = 19;
  localparam int PhW     = 24;
  localparam int NumW    = 24;
  localparam int RecipSh = 30;

  localparam logic [PhW-1:0] SlopeRst  = 24'hECD098;
  localparam logic [PhW-1:0] OffsetRst = 24'h290704;

  typedef struct packed {
    logic load;
    logic rotate;
  } chain_ctl_t;
endpackage
`default_nettype wire

### hdl/ph_tmf_cell.sv
`default_nettype none
module ph_tmf_cell (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            en_i,
  input  logic [ph_tmf_pkg::SampleW-1:0]  d_i,
  output logic [ph_tmf_pkg::SampleW-1:0]  q_o
);
  import ph_tmf_pkg::*;

  logic [SampleW-1:0] val_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val_q <= '0;
    end else if (en_i) begin
      val_q <= d_i;
    end
  end

  assign q_o = val_q;
endmodule
`default_nettype wire

### hdl/ph_tmf_chain.sv
`default_nettype none
module ph_tmf_chain #(
  parameter int WINDOW = 40
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  ph_tmf_pkg::chain_ctl_t          ctl_i,
  input  logic [ph_tmf_pkg::SampleW-1:0]  sample_i,
  output logic [ph_tmf_pkg::SampleW-1:0]  tail_o
);
  import ph_tmf_pkg::*;

  logic [SampleW-1:0] tap [WINDOW];
  logic [SampleW-1:0] head_d;
  logic               en;

  // A new sample pushes the oldest one out of the far end; during the walk
  // the row turns as a ring so every entry passes the tail once.
  assign en     = ctl_i.load | ctl_i.rotate;
  assign head_d = ctl_i.rotate ? tap[WINDOW-1] : sample_i;

  for (genvar k = 0; k < WINDOW; k++) begin : g_cell
    if (k == 0) begin : g_head
      ph_tmf_cell u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .en_i   (en),
        .d_i    (head_d),
        .q_o    (tap[k])
      );
    end else begin : g_body
      ph_tmf_cell u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .en_i   (en),
        .d_i    (tap[k-1]),
        .q_o    (tap[k])
      );
    end
  end

  assign tail_o = tap[WINDOW-1];
endmodule
`default_nettype wire

### hdl/ph_tmf_scale.sv
`default_nettype none
module ph_tmf_scale #(
  parameter int WINDOW = 40
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic [ph_tmf_pkg::NumW-1:0]        num_i,
  input  logic signed [ph_tmf_pkg::PhW-1:0]  slope_i,
  input  logic signed [ph_tmf_pkg::PhW-1:0]  offset_i,
  output logic                               done_o,
  output logic [ph_tmf_pkg::MeanW-1:0]       mean_q8_o,
  output logic [ph_tmf_pkg::VoltW-1:0]       volts_q16_o,
  output logic [ph_tmf_pkg::PhW-1:0]         ph_q16_o
);
  import ph_tmf_pkg::*;

  localparam bit Trim   = (WINDOW >= 5);
  localparam int Div    = Trim ? WINDOW - 2 : WINDOW;
  localparam int RecipW = RecipSh + 1;
  localparam int DivW   = 7;
  localparam int ProdW  = NumW + RecipW;
  localparam int QdW    = NumW + DivW;
  localparam int M5W    = MeanW + 3;
  localparam int MulW   = PhW + VoltW + 1;
  localparam int ShW    = MulW - 16;
  localparam int SumW   = ShW + 1;
  localparam logic [RecipW-1:0] Recip = RecipW'((longint'(1) << RecipSh) / Div);
  localparam logic [DivW-1:0]   DivC  = DivW'(Div);

  logic [5:1]             vld_q;
  logic [ProdW-1:0]       prod1_q;
  logic [NumW-1:0]        num1_q;
  logic [NumW-1:0]        q0;
  logic [QdW-1:0]         qd;
  logic [QdW-1:0]         rem;
  logic [NumW-1:0]        quo_q;
  logic [MeanW-1:0]       mean;
  logic [M5W-1:0]         mean5;
  logic [MeanW-1:0]       mean3_q, mean4_q, mean5_q;
  logic [VoltW-1:0]       volts3_q, volts4_q, volts5_q;
  logic signed [MulW-1:0] prod4_q;
  logic signed [ShW-1:0]  shifted;
  logic signed [SumW-1:0] ph_sum;
  logic [PhW-1:0]         ph_sat;
  logic [PhW-1:0]         ph5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[4:1], start_i};
    end
  end

  // The reciprocal estimate is low by at most one; one compare fixes it.
  assign q0  = prod1_q[RecipSh +: NumW];
  assign qd  = QdW'(q0) * QdW'(DivC);
  assign rem = QdW'(num1_q) - qd;

  assign mean  = Trim ? quo_q[MeanW-1:0] : {quo_q[SampleW-1:0], 8'h00};
  assign mean5 = M5W'(mean) + (M5W'(mean) << 2);

  // Arithmetic right shift by 16 floors the product.
  assign shifted = prod4_q[MulW-1:16];
  assign ph_sum  = SumW'(shifted) + SumW'(offset_i);

  always_comb begin
    if (!ph_sum[SumW-1] && (ph_sum[SumW-2:PhW-1] != '0)) begin
      ph_sat = {1'b0, {(PhW-1){1'b1}}};
    end else if (ph_sum[SumW-1] && (ph_sum[SumW-2:PhW-1] != '1)) begin
      ph_sat = {1'b1, {(PhW-1){1'b0}}};
    end else begin
      ph_sat = ph_sum[PhW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    prod1_q  <= ProdW'(num_i) * ProdW'(Recip);
    num1_q   <= num_i;
    quo_q    <= (rem >= QdW'(DivC)) ? q0 + NumW'(1) : q0;
    mean3_q  <= mean;
    volts3_q <= mean5[M5W-1:2];
    prod4_q  <= slope_i * $signed({1'b0, volts3_q});
    mean4_q  <= mean3_q;
    volts4_q <= volts3_q;
    mean5_q  <= mean4_q;
    volts5_q <= volts4_q;
    ph5_q    <= ph_sat;
  end

  assign done_o      = vld_q[5];
  assign mean_q8_o   = mean5_q;
  assign volts_q16_o = volts5_q;
  assign ph_q16_o    = ph5_q;
endmodule
`default_nettype wire

### hdl/ph_trimmed_mean_filter_top.sv
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+------------------------------------
//  in      | input     | in_valid_i / in_stall_o    | sample_i
//  out     | output    | out_valid_o / out_stall_i  | mean_q8_o, volts_q16_o, ph_q16_o
//  cfg     | input     | psel / penable / pready    | paddr, pwdata, prdata
//
//  Each request shifts the sample into the cell row, turns the row once past the sum,
//  minimum and maximum accumulator, starts the scaling pipeline, waits until its
//  result is seen and then loads the output register, which holds off while a stalled
//  result still sits in it. The next request is taken the cycle after that load.
//  Reset clears the window to zeros and restores the slope and offset defaults.
//  A stalled result sits in the output register while the next request is computed.
`default_nettype none
module ph_trimmed_mean_filter_top #(
  parameter int WINDOW = 40
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [ph_tmf_pkg::SampleW-1:0]    sample_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [ph_tmf_pkg::MeanW-1:0]      mean_q8_o,
  output logic [ph_tmf_pkg::VoltW-1:0]      volts_q16_o,
  output logic signed [ph_tmf_pkg::PhW-1:0] ph_q16_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [2:0]                        paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);
  import ph_tmf_pkg::*;
  `include "ph_trimmed_mean_filter_top_macros.svh"

  localparam bit Trim = (WINDOW >= 5);
  localparam int SumW = $clog2(WINDOW * 1023 + 1);
  localparam int CntW = (WINDOW > 1) ? $clog2(WINDOW) : 1;

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StWalk  = 3'd1;
  localparam logic [2:0] StStart = 3'd2;
  localparam logic [2:0] StWait  = 3'd3;
  localparam logic [2:0] StLoad  = 3'd4;

  logic [2:0]          state_q, state_d;
  logic [CntW-1:0]     cnt_q;
  logic [SumW-1:0]     sum_q;
  logic [SampleW-1:0]  lo_q, hi_q;
  logic [SampleW-1:0]  tail;
  logic                accept;
  logic                load_out;
  logic                walk_last;
  chain_ctl_t          ctl;
  logic [NumW-1:0]     num;
  logic                scale_done;
  logic [MeanW-1:0]    scale_mean;
  logic [VoltW-1:0]    scale_volts;
  logic [PhW-1:0]      scale_ph;
  logic                out_valid_q;
  logic [MeanW-1:0]    mean_q;
  logic [VoltW-1:0]    volts_q;
  logic [PhW-1:0]      ph_q;
  logic signed [PhW-1:0] slope_q, offset_q;
  logic                cfg_wr;

  // Configuration registers.
  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'(offset_q) : 32'(slope_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slope_q  <= SlopeRst;
      offset_q <= OffsetRst;
    end else if (cfg_wr) begin
      if (paddr[2]) begin
        offset_q <= pwdata[PhW-1:0];
      end else begin
        slope_q <= pwdata[PhW-1:0];
      end
    end
  end

  // Sequencer.
  assign accept     = in_valid_i && (state_q == StIdle);
  assign in_stall_o = (state_q != StIdle);
  assign walk_last  = (cnt_q == CntW'(WINDOW - 1));
  assign load_out   = (state_q == StLoad) && (!out_valid_q || !out_stall_i);
  assign ctl.load   = accept;
  assign ctl.rotate = (state_q == StWalk);

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle:  if (in_valid_i) state_d = StWalk;
      StWalk:  if (walk_last) state_d = StStart;
      StStart: state_d = StWait;
      StWait:  if (scale_done) state_d = StLoad;
      StLoad:  if (load_out) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        cnt_q <= '0;
      end else if (state_q == StWalk) begin
        cnt_q <= cnt_q + CntW'(1);
      end
    end
  end

  ph_tmf_chain #(
    .WINDOW (WINDOW)
  ) u_chain (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (ctl),
    .sample_i (sample_i),
    .tail_o   (tail)
  );

  always_ff @(posedge clk_i) begin
    if (accept) begin
      sum_q <= '0;
      lo_q  <= '1;
      hi_q  <= '0;
    end else if (state_q == StWalk) begin
      sum_q <= sum_q + SumW'(tail);
      lo_q  <= (tail < lo_q) ? tail : lo_q;
      hi_q  <= (tail > hi_q) ? tail : hi_q;
    end
  end

  // Short windows take the plain mean; otherwise the extremes are dropped.
  assign num = Trim ? (NumW'(sum_q - SumW'(lo_q) - SumW'(hi_q)) << 8) : NumW'(sum_q);

  ph_tmf_scale #(
    .WINDOW (WINDOW)
  ) u_scale (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (state_q == StStart),
    .num_i       (num),
    .slope_i     (slope_q),
    .offset_i    (offset_q),
    .done_o      (scale_done),
    .mean_q8_o   (scale_mean),
    .volts_q16_o (scale_volts),
    .ph_q16_o    (scale_ph)
  );

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      mean_q  <= scale_mean;
      volts_q <= scale_volts;
      ph_q    <= scale_ph;
    end
  end

  assign out_valid_o = out_valid_q;
  assign mean_q8_o   = mean_q;
  assign volts_q16_o = volts_q;
  assign ph_q16_o    = ph_q;

  `PH_ASSERT(a_accept_walk, clk_i, rst_ni, (in_valid_i && !in_stall_o) |=> (state_q == StWalk), "accepted request did not start the walk")
  `PH_ASSERT(a_min_max, clk_i, rst_ni, (state_q == StStart) |-> (lo_q <= hi_q), "window minimum exceeds maximum")
  `PH_ASSERT(a_done_wait, clk_i, rst_ni, scale_done |-> (state_q == StWait), "scaling result arrived outside the wait state")
  `PH_ASSERT_RST(a_reset_idle, clk_i, !rst_ni |=> (!out_valid_o && !in_stall_o), "block not idle in reset")
endmodule
`default_nettype wire

### verif/ph_trimmed_mean_filter_top_tb.sv
`default_nettype none
module ph_trimmed_mean_filter_top_tb;
  import ph_tmf_pkg::*;

  localparam int WinLen     = 40;
  localparam int IdleLimit  = 2000;
  localparam int RandPhases = 6;
  localparam int RandItems  = 125;

  typedef enum int {
    RegSlope  = 0,
    RegOffset = 1
  } ph_reg_e;

  localparam logic signed [PhW-1:0] PhMax = 24'sh7FFFFF;
  localparam logic signed [PhW-1:0] PhMin = -24'sh800000;

  typedef struct {
    logic [MeanW-1:0]        mean_q8;
    logic [VoltW-1:0]        volts_q16;
    logic signed [PhW-1:0]   ph_q16;
  } ph_reading_t;

  class ph_reading_scoreboard;
    logic [SampleW-1:0] window_q[WinLen];
    int unsigned        wr_idx;
    longint             slope;
    longint             offset;
    ph_reading_t        pending_readings[$];
    int                 errors;
    int                 samples_taken;
    int                 readings_checked;

    function new();
      foreach (window_q[i]) window_q[i] = '0;
      wr_idx = 0;
      slope = longint'($signed(SlopeRst));
      offset = longint'($signed(OffsetRst));
      errors = 0;
      samples_taken = 0;
      readings_checked = 0;
    endfunction

    function void set_reg(ph_reg_e idx, logic [31:0] value);
      logic signed [PhW-1:0] v;
      v = value[PhW-1:0];
      if (idx == RegSlope) slope = v;
      else if (idx == RegOffset) offset = v;
    endfunction

    function ph_reading_t predict_ph_reading();
      ph_reading_t r;
      int unsigned total;
      int unsigned lo;
      int unsigned hi;
      int unsigned mean;
      int unsigned volts;
      longint      ph;
      total = 0;
      lo = 1023;
      hi = 0;
      foreach (window_q[i]) begin
        total += window_q[i];
        if (window_q[i] < lo) lo = window_q[i];
        if (window_q[i] > hi) hi = window_q[i];
      end
      // Small windows fall back to a plain mean with the fraction dropped.
      if (WinLen < 5) mean = (total / WinLen) << 8;
      else mean = ((total - lo - hi) << 8) / (WinLen - 2);
      volts = (mean * 5) >> 2;
      // The arithmetic shift floors toward minus infinity.
      ph = ((slope * longint'(volts)) >>> 16) + offset;
      if (ph > longint'(PhMax)) ph = PhMax;
      if (ph < longint'(PhMin)) ph = PhMin;
      r.mean_q8 = mean[MeanW-1:0];
      r.volts_q16 = volts[VoltW-1:0];
      r.ph_q16 = ph[PhW-1:0];
      return r;
    endfunction

    function void note_sample(logic [SampleW-1:0] s);
      window_q[wr_idx] = s;
      wr_idx = (wr_idx + 1 >= WinLen) ? 0 : wr_idx + 1;
      pending_readings.push_back(predict_ph_reading());
      samples_taken++;
    endfunction

    function void check_reading(logic [MeanW-1:0] mean_q8, logic [VoltW-1:0] volts_q16,
                                logic signed [PhW-1:0] ph_q16);
      ph_reading_t exp_r;
      if (pending_readings.size() == 0) begin
        $error("unexpected result: mean_q8=%0d volts_q16=%0d ph_q16=%0d",
               mean_q8, volts_q16, ph_q16);
        errors++;
        return;
      end
      exp_r = pending_readings.pop_front();
      readings_checked++;
      if (mean_q8 !== exp_r.mean_q8) begin
        $error("mean_q8: expected %0d, got %0d", exp_r.mean_q8, mean_q8);
        errors++;
      end
      if (volts_q16 !== exp_r.volts_q16) begin
        $error("volts_q16: expected %0d, got %0d", exp_r.volts_q16, volts_q16);
        errors++;
      end
      if (ph_q16 !== exp_r.ph_q16) begin
        $error("ph_q16: expected %0d, got %0d", exp_r.ph_q16, ph_q16);
        errors++;
      end
    endfunction
  endclass

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   in_valid_i = 1'b0;
  logic                   in_stall_o;
  logic [SampleW-1:0]     sample_i = '0;
  logic                   out_valid_o;
  logic                   out_stall_i = 1'b0;
  logic [MeanW-1:0]       mean_q8_o;
  logic [VoltW-1:0]       volts_q16_o;
  logic signed [PhW-1:0]  ph_q16_o;
  logic                   psel = 1'b0;
  logic                   penable = 1'b0;
  logic                   pwrite = 1'b0;
  logic [2:0]             paddr = '0;
  logic [31:0]            pwdata = '0;
  logic [31:0]            prdata;
  logic                   pready;

  bit                     steady_run = 1'b0;
  int                     idle_cycles = 0;
  int                     settings_used = 1;
  ph_reading_scoreboard   sb = new();

  ph_trimmed_mean_filter_top #(.WINDOW(WinLen)) i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .sample_i    (sample_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .mean_q8_o   (mean_q8_o),
    .volts_q16_o (volts_q16_o),
    .ph_q16_o    (ph_q16_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(negedge clk_i) begin
    out_stall_i <= steady_run ? 1'b0 : ($urandom_range(99) < 20);
  end

  // Prediction, checking and the watchdog all look at the pre-edge values.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) sb.note_sample(sample_i);
      if (out_valid_o && !out_stall_i) sb.check_reading(mean_q8_o, volts_q16_o, ph_q16_o);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (psel && penable && pwrite && pready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IdleLimit) begin
        $display("Simulation FAILED");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  task automatic write_reg(ph_reg_e idx, logic signed [PhW-1:0] value);
    logic [31:0] word;
    // Bits above the register width are filled with noise; the block drops them.
    word = {8'($urandom_range(255)), value};
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 3'(4 * idx);
    pwdata <= word;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.set_reg(idx, word);
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic send_sample(logic [SampleW-1:0] s);
    while (!steady_run && $urandom_range(99) < 20) begin
      in_valid_i <= 1'b0;
      sample_i <= SampleW'($urandom_range(1023));
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_i <= s;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  task automatic drain_readings();
    in_valid_i <= 1'b0;
    while (sb.pending_readings.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic apply_setting(logic signed [PhW-1:0] slope_v, logic signed [PhW-1:0] offset_v);
    drain_readings();
    write_reg(RegSlope, slope_v);
    write_reg(RegOffset, offset_v);
    settings_used++;
  endtask

  function automatic logic signed [PhW-1:0] pick_coeff();
    case ($urandom_range(5))
      0: return PhMax;
      1: return PhMin;
      2: return '0;
      default: return PhW'($urandom);
    endcase
  endfunction

  // Mostly a steady probe level with jitter, plus spikes that the trimming must reject.
  function automatic logic [SampleW-1:0] pick_sample(int level);
    int v;
    case ($urandom_range(19))
      0, 1: return '0;
      2, 3: return '1;
      4, 5, 6: return SampleW'($urandom_range(1023));
      default: begin
        v = level + $urandom_range(16) - 8;
        if (v < 0) v = 0;
        if (v > 1023) v = 1023;
        return SampleW'(v);
      end
    endcase
  endfunction

  initial begin
    logic [SampleW-1:0] warmup[];
    int level;
    warmup = '{10'd0, 10'd1023, 10'd1023, 10'd1, 10'd1022, 10'h155,
               10'h2AA, 10'd512, 10'd511, 10'd0, 10'd1023};
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset defaults first, then both saturation limits, then a slope whose
    // product with any nonzero voltage below one volt floors to minus one.
    foreach (warmup[i]) send_sample(warmup[i]);
    apply_setting(PhMax, PhMax);
    send_sample(10'd1023);
    send_sample(10'd0);
    send_sample(10'd700);
    apply_setting(PhMin, PhMin);
    send_sample(10'd1023);
    send_sample(10'd900);
    send_sample(10'd0);
    apply_setting(-24'sd1, '0);
    send_sample(10'd1023);
    send_sample(10'd3);
    send_sample(10'd1023);

    for (int ph_run = 0; ph_run < RandPhases; ph_run++) begin
      if (ph_run == 0) apply_setting(SlopeRst, OffsetRst);
      else apply_setting(pick_coeff(), pick_coeff());
      steady_run = (ph_run == 2);
      level = $urandom_range(1023);
      for (int n = 0; n < RandItems; n++) begin
        if ($urandom_range(49) == 0) level = $urandom_range(1023);
        send_sample(pick_sample(level));
      end
      steady_run = 1'b0;
    end

    drain_readings();
    repeat (60) @(posedge clk_i);
    if (sb.pending_readings.size() != 0) begin
      $error("%0d expected results never arrived", sb.pending_readings.size());
      sb.errors++;
    end
    $display("Ran %0d probe samples through %0d slope/offset settings, %0d readings checked.",
             sb.samples_taken, settings_used, sb.readings_checked);
    $display("Covered window wrap, outlier rejection, pH saturation at both limits.");
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire
